// ===== rtl/rc4_stream_cipher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rc4 stream cipher unit assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

// same-cycle implication
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4 package
// request codes, sizes and the controller/datapath command and status types
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int unsigned KEY_DEPTH_DEF = 256;
	localparam int unsigned PERM_DEPTH    = 256;

	// request action codes
	localparam logic [1:0] ACT_KEY     = 2'd0;
	localparam logic [1:0] ACT_DATA    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	typedef struct packed {
		logic key_write;
		logic data_start;
		logic data_rd_j;
		logic data_sw_i;
		logic data_sw_j;
		logic sched_init;
		logic sched_read;
		logic sched_acc;
		logic sched_wr_n;
		logic sched_wr_acc;
	} rc4_cmd_t;

	typedef struct packed {
		logic key_empty;
		logic n_last;
	} rc4_status_t;

endpackage

// ===== rtl/rc4_req_if.sv =====
// ----------------------------------------------------------------------------
// rc4 request channel
// valid/ready channel carrying one key, data or restart request
// ----------------------------------------------------------------------------
interface rc4_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] value;
	logic       key_last;

	modport source (output valid, action, value, key_last, input ready);
	modport sink   (input valid, action, value, key_last, output ready);
endinterface

// ===== rtl/rc4_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rc4 result channel
// valid/ready channel carrying one output data byte
// ----------------------------------------------------------------------------
interface rc4_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;

	modport source (output valid, data_out, input ready);
	modport sink   (input valid, data_out, output ready);
endinterface

// ===== rtl/rc4_dpath.sv =====
// ----------------------------------------------------------------------------
// rc4 datapath
// permutation memory, key memory, stream indices, schedule counters, output
// ----------------------------------------------------------------------------
module rc4_dpath #(
	parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rc4_pkg::rc4_cmd_t   cmd,
	input  logic [7:0]          value,
	output rc4_pkg::rc4_status_t status,
	output logic [7:0]          data_out
);
	import rc4_pkg::*;

	localparam int unsigned KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int unsigned CW = $clog2(KEY_DEPTH + 1);
	localparam int unsigned PW = $clog2(PERM_DEPTH);

	// permutation memory with per-entry valid; invalid entries read as identity
	logic [7:0]            perm_mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] perm_vld_q;
	logic [7:0]            prd_data_q;
	logic                  prd_vld_q;
	logic [PW-1:0]         prd_addr_q;
	logic [7:0]            perm_rd;

	logic [7:0] key_mem [KEY_DEPTH];
	logic [7:0] key_rd_q;

	logic [7:0]    i_q, j_q;
	logic [CW-1:0] key_count_q;
	logic [KW-1:0] kidx_q;
	logic [CW-1:0] kidx_nxt;
	logic [7:0]    n_q, acc_q, sn_q;
	logic [7:0]    si_q, sj_q, t_q, value_q, dout_q;
	logic [7:0]    acc_sum;
	logic [7:0]    ks;
	logic          key_full;

	logic          pr_en, pw_en;
	logic [PW-1:0] pr_addr, pw_addr;
	logic [7:0]    pw_data;

	assign perm_rd  = prd_vld_q ? prd_data_q : prd_addr_q;
	assign acc_sum  = acc_q + perm_rd + key_rd_q;
	assign key_full = (key_count_q == CW'(KEY_DEPTH));
	assign kidx_nxt = CW'(kidx_q) + CW'(1);

	// keystream byte from the swapped table, bypassing the two fresh writes
	always_comb begin
		if (t_q == j_q)
			ks = si_q;
		else if (t_q == i_q)
			ks = sj_q;
		else
			ks = perm_rd;
	end

	always_comb begin
		pr_en   = 1'b1;
		pr_addr = '0;
		if (cmd.data_start)
			pr_addr = i_q + 8'd1;
		else if (cmd.data_rd_j)
			pr_addr = j_q + perm_rd;
		else if (cmd.data_sw_i)
			pr_addr = si_q + perm_rd;
		else if (cmd.sched_read)
			pr_addr = n_q;
		else if (cmd.sched_acc)
			pr_addr = acc_sum;
		else
			pr_en = 1'b0;
	end

	always_comb begin
		pw_en   = 1'b1;
		pw_addr = '0;
		pw_data = '0;
		if (cmd.data_sw_i) begin
			pw_addr = i_q;
			pw_data = perm_rd;
		end else if (cmd.data_sw_j) begin
			pw_addr = j_q;
			pw_data = si_q;
		end else if (cmd.sched_wr_n) begin
			pw_addr = n_q;
			pw_data = perm_rd;
		end else if (cmd.sched_wr_acc) begin
			pw_addr = acc_q;
			pw_data = sn_q;
		end else begin
			pw_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pw_en)
			perm_mem[pw_addr] <= pw_data;
		if (pr_en) begin
			prd_data_q <= perm_mem[pr_addr];
			prd_vld_q  <= perm_vld_q[pr_addr];
			prd_addr_q <= pr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
		end else if (cmd.sched_init) begin
			perm_vld_q <= '0;
		end else if (pw_en) begin
			perm_vld_q[pw_addr] <= 1'b1;
		end
	end

	// key memory
	always_ff @(posedge clk) begin
		if (cmd.key_write && !key_full)
			key_mem[key_count_q[KW-1:0]] <= value;
		if (cmd.sched_read)
			key_rd_q <= key_mem[kidx_q];
	end

	// stream indices and key length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			key_count_q <= '0;
		end else begin
			if (cmd.key_write && !key_full)
				key_count_q <= key_count_q + CW'(1);
			if (cmd.data_start)
				i_q <= i_q + 8'd1;
			if (cmd.data_rd_j)
				j_q <= j_q + perm_rd;
			if (cmd.sched_wr_acc && status.n_last) begin
				i_q <= '0;
				j_q <= '0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.data_start)
			value_q <= value;
		if (cmd.data_rd_j)
			si_q <= perm_rd;
		if (cmd.data_sw_i) begin
			sj_q <= perm_rd;
			t_q  <= si_q + perm_rd;
		end
		if (cmd.data_sw_j)
			dout_q <= value_q ^ ks;
		if (cmd.sched_init) begin
			acc_q  <= '0;
			n_q    <= '0;
			kidx_q <= '0;
		end
		if (cmd.sched_acc) begin
			acc_q <= acc_sum;
			sn_q  <= perm_rd;
		end
		if (cmd.sched_wr_acc) begin
			n_q <= n_q + 8'd1;
			if (kidx_nxt == key_count_q)
				kidx_q <= '0;
			else
				kidx_q <= kidx_nxt[KW-1:0];
		end
	end

	assign status.key_empty = (key_count_q == '0);
	assign status.n_last    = (n_q == 8'hFF);
	assign data_out         = dout_q;

endmodule

// ===== rtl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4 controller
// sequences data requests and the key schedule, owns the result valid flag
// ----------------------------------------------------------------------------
module rc4_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic [1:0]           req_action,
	input  logic                 req_key_last,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rc4_pkg::rc4_status_t status,
	output rc4_pkg::rc4_cmd_t    cmd
);
	import rc4_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_D_RDJ  = 9'b000000010,
		ST_D_SWI  = 9'b000000100,
		ST_D_SWJ  = 9'b000001000,
		ST_K_INIT = 9'b000010000,
		ST_K_RD   = 9'b000100000,
		ST_K_ACC  = 9'b001000000,
		ST_K_WRN  = 9'b010000000,
		ST_K_WRA  = 9'b100000000
	} rc4_state_t;

	rc4_state_t state_q, state_d;
	logic       out_valid_q;
	logic       req_fire;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req_action)
						ACT_KEY: begin
							cmd.key_write = 1'b1;
							if (req_key_last)
								state_d = ST_K_INIT;
						end
						ACT_DATA: begin
							cmd.data_start = 1'b1;
							state_d        = ST_D_RDJ;
						end
						ACT_RESTART: begin
							if (!status.key_empty)
								state_d = ST_K_INIT;
						end
						default: ;
					endcase
				end
			end
			ST_D_RDJ: begin
				cmd.data_rd_j = 1'b1;
				state_d       = ST_D_SWI;
			end
			ST_D_SWI: begin
				cmd.data_sw_i = 1'b1;
				state_d       = ST_D_SWJ;
			end
			ST_D_SWJ: begin
				// hold until the output slot is free or draining
				if (!out_valid_q || rsp_ready) begin
					cmd.data_sw_j = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_K_INIT: begin
				cmd.sched_init = 1'b1;
				state_d        = ST_K_RD;
			end
			ST_K_RD: begin
				cmd.sched_read = 1'b1;
				state_d        = ST_K_ACC;
			end
			ST_K_ACC: begin
				cmd.sched_acc = 1'b1;
				state_d       = ST_K_WRN;
			end
			ST_K_WRN: begin
				cmd.sched_wr_n = 1'b1;
				state_d        = ST_K_WRA;
			end
			ST_K_WRA: begin
				cmd.sched_wr_acc = 1'b1;
				state_d          = status.n_last ? ST_IDLE : ST_K_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.data_sw_j)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/rc4_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// rc4 stream cipher unit
// arcfour keystream generator with key store and on-chip key schedule
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                      moves
//  req      in   action, value, key_last     key byte, data byte or restart
//  rsp      out  data_out                    data byte xor keystream byte
//
//  a data request runs from accept to result through i lookup, j lookup,
//  swap with keystream read, second swap write; all go through the single
//  read and single write port of the permutation memory
//  a key schedule runs an init step, then one step per permutation entry
//  (four memory accesses per step); key and restart requests give no result
//  after reset the permutation reads as identity through per-entry valid
//  bits, so no clearing pass is needed
//  a finished result waits in the output register; a new request is taken
//  meanwhile, and a data request holds in its last step until that slot frees
//
module rc4_stream_cipher_unit #(
	parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rc4_req_if.sink     req,
	rc4_rsp_if.source   rsp
);
	import rc4_pkg::*;

	rc4_cmd_t    cmd;
	rc4_status_t status;

	// controller: request decode, data and schedule sequencing, result flag
	rc4_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_action   (req.action),
		.req_key_last (req.key_last),
		.req_ready    (req.ready),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// datapath: permutation and key memories, indices, output register
	rc4_dpath #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (req.value),
		.status   (status),
		.data_out (rsp.data_out)
	);

endmodule

// ===== rtl/rc4_checker.sv =====
// ----------------------------------------------------------------------------
// rc4 port checker
// timing checks on the request and result channels, bound to the top level
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_unit_macros.svh"

module rc4_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_action,
	input logic       req_key_last,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_data_out
);
	import rc4_pkg::*;

	logic data_req;
	logic sched_req;

	assign data_req  = req_valid && req_ready && (req_action == ACT_DATA);
	assign sched_req = req_valid && req_ready && (req_action == ACT_KEY) && req_key_last;

	`RC4_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out), "result dropped or changed while stalled")
	`RC4_ASSERT_NXT(a_data_busy, clk, arst_n, data_req, !req_ready, "request taken during data work")
	`RC4_ASSERT_NXT(a_sched_busy, clk, arst_n, sched_req, !req_ready ##1 !req_ready, "request taken during key schedule")
	`RC4_ASSERT_IMP(a_rsp_origin, clk, arst_n, $rose(rsp_valid), $past(data_req, 4), "result without a data request four cycles before")

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_action   (req.action),
	.req_key_last (req.key_last),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_data_out (rsp.data_out)
);
